// File: hdl/tile_piece_blit_top_assert.svh
// Assertion macros shared by the checker of tile_piece_blit_top.
// Each macro expects clk and rst_n in scope.
`ifndef TILE_PIECE_BLIT_TOP_ASSERT_SVH
`define TILE_PIECE_BLIT_TOP_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define TPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the next edge after the antecedent.
`define TPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg
// Types and constants shared by the color-key blit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpb_pkg;

    localparam int DIM_W      = 7;    // dimension registers and counters
    localparam int IDX_W      = 14;   // linear index before range check
    localparam int POS_W      = 10;   // signed destination coordinate
    localparam int ADDR_W     = 12;
    localparam int PIX_W      = 8;
    localparam int SRCO_W     = 6;
    localparam int DSTO_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int MAX_EDGE   = 64;

    localparam logic [PIX_W-1:0] TRANSPARENT_PIXEL = 8'd255;

    // s_axis_tdata field positions
    localparam int ADDR_LSB   = 0;
    localparam int PIXEL_LSB  = 12;
    localparam int SRC_X_LSB  = 20;
    localparam int SRC_Y_LSB  = 26;
    localparam int DST_X_LSB  = 32;
    localparam int DST_Y_LSB  = 40;
    localparam int SIZE_X_LSB = 48;
    localparam int SIZE_Y_LSB = 55;

    typedef enum logic [FUNC_W-1:0] {
        FN_WR_SRC = 2'd0,
        FN_WR_DST = 2'd1,
        FN_BLIT   = 2'd2,
        FN_RD_DST = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_SKIP   = 2'd1,
        STAT_REJECT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COL,
        ST_PIX,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic col_start;  // set up column base addresses
        logic pix_step;   // issue one pixel, advance the walk
        logic push_read;  // load read result into output register
        logic push_blit;  // load blit status into output register
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  blit_run;  // blit passes checks and has a nonempty rectangle
        logic  row_last;
        logic  col_last;
        logic  out_busy;  // output register full and not drained this cycle
    } sts_t;

endpackage

`default_nettype wire

// File: hdl/tile_piece_blit_top.sv
// ----------------------------------------------------------------------------
// tile_piece_blit_top
// Color-key blit engine between two column-major 8-bit pixel tiles.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A pixel write is stored as its beat is taken;
// a destination read passes the registered read data of the destination store
// to the output register from the read state. A blit that is skipped, rejected
// or has an empty rectangle reports in the next cycle; otherwise it walks the
// rectangle column by column, a setup state per column (base address multiply)
// and a pixel step per pixel through the single read port of the source store,
// then drains before its status appears. Results sit in an output register;
// the next beat is taken only when that register is empty or its result leaves
// in the same cycle, so a stalled result stalls the input. The two pixel stores
// are not cleared after reset: every entry must be written before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tile_piece_blit_top #(
    parameter int TILE_PIXELS = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // config
    input  wire logic                                cfg_wr_en,
    input  wire logic [tpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tpb_pkg::DIM_W-1:0]           cfg_wr_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // address[11:0], pixel[19:12], src_x[25:20], src_y[31:26], dst_x[39:32],
    // dst_y[47:40], size_x[54:48], size_y[61:55], zero[63:62]
    input  wire logic [tpb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func[1:0]
    input  wire logic [tpb_pkg::FUNC_W-1:0]          s_axis_tuser,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // read_pixel[7:0], status[9:8], zero[15:10]
    output logic      [tpb_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import tpb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tpb_dp #(
        .TILE_PIXELS (TILE_PIXELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .in_func     (s_axis_tuser),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// File: hdl/tpb_ram.sv
// ----------------------------------------------------------------------------
// tpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/tpb_ctrl.sv
// ----------------------------------------------------------------------------
// tpb_ctrl
// Sequencer for host accesses and the column-by-column blit walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tpb_pkg::sts_t sts,
    output tpb_pkg::cmd_t      cmd
);
    import tpb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && !sts.out_busy;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (sts.func)
                        FN_RD_DST: state_next = ST_READ;
                        FN_BLIT:   state_next = sts.blit_run ? ST_COL : ST_IDLE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_COL:   state_next = ST_PIX;
            ST_PIX:
            begin
                priority if (sts.row_last && sts.col_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (sts.row_last)
                begin
                    state_next = ST_COL;
                end
                else
                begin
                    state_next = ST_PIX;
                end
            end
            ST_DRAIN: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.push_read = (state_reg == ST_READ);
        cmd.col_start = (state_reg == ST_COL);
        cmd.pix_step  = (state_reg == ST_PIX);
        // rejected, skipped and empty blits report at once
        cmd.push_blit = (accept && sts.func == FN_BLIT && !sts.blit_run)
                        || (state_reg == ST_DRAIN);
    end

endmodule

`default_nettype wire

// File: hdl/tpb_dp.sv
// ----------------------------------------------------------------------------
// tpb_dp
// Tile stores, blit address walk, write-back stage and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpb_dp #(
    parameter int TILE_PIXELS = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tpb_pkg::DIM_W-1:0]         cfg_wr_data,
    input  wire logic [tpb_pkg::IN_DATA_W-1:0]     in_data,
    input  wire logic [tpb_pkg::FUNC_W-1:0]        in_func,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic      [tpb_pkg::OUT_DATA_W-1:0]    out_data,
    input  wire tpb_pkg::cmd_t                     cmd,
    output tpb_pkg::sts_t                          sts
);
    import tpb_pkg::*;

    localparam int AW = $clog2(TILE_PIXELS);

    // configuration
    logic [DIM_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [DIM_W-1:0] sw, sh, dw, dh;

    // decoded input beat
    func_t              func;
    logic [ADDR_W-1:0]  addr_in;
    logic [PIX_W-1:0]   pixel_in;
    logic [SRCO_W-1:0]  src_x_in, src_y_in;
    logic [DSTO_W-1:0]  dst_x_in, dst_y_in;
    logic [DIM_W-1:0]   size_x_in, size_y_in;
    logic               host_inside;
    logic [AW-1:0]      host_addr;
    status_t            blit_status;

    // walk state
    logic [DIM_W-1:0] x1_reg, x1_next, y1_reg, y1_next, sy0_reg, sy0_next;
    logic [POS_W-1:0] x2_reg, x2_next, y2_reg, y2_next;
    logic [DSTO_W-1:0] dy0_reg, dy0_next;
    logic [DIM_W-1:0] i_cnt_reg, i_cnt_next, j_cnt_reg, j_cnt_next;
    logic [DIM_W-1:0] ny_reg, ny_next;
    logic [IDX_W-1:0] sbase_reg, sbase_next, dbase_reg, dbase_next;
    logic [DIM_W:0]   y1_inc, x1_inc;
    logic [IDX_W-1:0] si, di;
    logic             src_ok, dst_ok;

    // write-back stage
    logic          pend_reg, pend_next;
    logic          pend_sok_reg, pend_sok_next;
    logic          pend_dok_reg, pend_dok_next;
    logic [AW-1:0] pend_di_reg, pend_di_next;
    logic          rd_inside_reg, rd_inside_next;

    // memories
    logic             src_we, dst_we, host_dst_we, blit_we;
    logic [AW-1:0]    dst_waddr;
    logic [PIX_W-1:0] dst_wdata, src_rdata, dst_rdata, blit_pix;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_pixel_reg, out_pixel_next;
    status_t            out_status_reg, out_status_next;

    function automatic logic [DIM_W-1:0] clamp_edge(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (32'(v) > 32'(MAX_EDGE))
        begin
            r = DIM_W'(MAX_EDGE);
        end
        return r;
    endfunction

    // ------------------------------------------------------------ config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            dst_w_reg <= '0;
            dst_h_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SRC_WIDTH:  src_w_reg <= cfg_wr_data;
                CFG_SRC_HEIGHT: src_h_reg <= cfg_wr_data;
                CFG_DST_WIDTH:  dst_w_reg <= cfg_wr_data;
                CFG_DST_HEIGHT: dst_h_reg <= cfg_wr_data;
                default:        src_w_reg <= src_w_reg;
            endcase
        end
    end

    assign sw = clamp_edge(src_w_reg);
    assign sh = clamp_edge(src_h_reg);
    assign dw = clamp_edge(dst_w_reg);
    assign dh = clamp_edge(dst_h_reg);

    // ------------------------------------------------------------ decode
    assign func      = func_t'(in_func);
    assign addr_in   = in_data[ADDR_LSB +: ADDR_W];
    assign pixel_in  = in_data[PIXEL_LSB +: PIX_W];
    assign src_x_in  = in_data[SRC_X_LSB +: SRCO_W];
    assign src_y_in  = in_data[SRC_Y_LSB +: SRCO_W];
    assign dst_x_in  = in_data[DST_X_LSB +: DSTO_W];
    assign dst_y_in  = in_data[DST_Y_LSB +: DSTO_W];
    assign size_x_in = in_data[SIZE_X_LSB +: DIM_W];
    assign size_y_in = in_data[SIZE_Y_LSB +: DIM_W];

    assign host_inside = 32'(addr_in) < 32'(TILE_PIXELS);
    assign host_addr   = AW'(addr_in);

    always_comb
    begin
        priority if (sw == '0 || sh == '0 || dw == '0 || dh == '0)
        begin
            blit_status = STAT_SKIP;
        end
        else if (DIM_W'(src_x_in) >= sw || DIM_W'(src_y_in) >= sh)
        begin
            blit_status = STAT_REJECT;
        end
        else
        begin
            blit_status = STAT_OK;
        end
    end

    assign sts.func     = func;
    assign sts.blit_run = (blit_status == STAT_OK) && (size_x_in != '0)
                          && (size_y_in != '0);
    assign sts.row_last = (j_cnt_reg == DIM_W'(1));
    assign sts.col_last = (i_cnt_reg == DIM_W'(1));
    assign sts.out_busy = out_valid_reg && !out_ready;

    // ------------------------------------------------------------ walk
    assign y1_inc = {1'b0, y1_reg} + 1'b1;
    assign x1_inc = {1'b0, x1_reg} + 1'b1;
    assign si     = sbase_reg + IDX_W'(y1_reg);
    assign di     = dbase_reg + IDX_W'(y2_reg[DIM_W-1:0]);
    assign src_ok = 32'(si) < 32'(TILE_PIXELS);
    // clip to the destination tile; sign bit marks a negative coordinate
    assign dst_ok = !x2_reg[POS_W-1] && (x2_reg[POS_W-2:0] < (POS_W-1)'(dw))
                    && !y2_reg[POS_W-1] && (y2_reg[POS_W-2:0] < (POS_W-1)'(dh))
                    && (32'(di) < 32'(TILE_PIXELS));

    always_comb
    begin
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        sy0_next   = sy0_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        dy0_next   = dy0_reg;
        i_cnt_next = i_cnt_reg;
        j_cnt_next = j_cnt_reg;
        ny_next    = ny_reg;
        sbase_next = sbase_reg;
        dbase_next = dbase_reg;
        if (cmd.accept)
        begin
            x1_next    = DIM_W'(src_x_in);
            sy0_next   = DIM_W'(src_y_in);
            x2_next    = {{(POS_W-DSTO_W){dst_x_in[DSTO_W-1]}}, dst_x_in};
            dy0_next   = dst_y_in;
            i_cnt_next = size_x_in;
            ny_next    = size_y_in;
        end
        if (cmd.col_start)
        begin
            sbase_next = IDX_W'(x1_reg) * IDX_W'(sh);
            dbase_next = IDX_W'(x2_reg[DIM_W-1:0]) * IDX_W'(dh);
            y1_next    = sy0_reg;
            y2_next    = {{(POS_W-DSTO_W){dy0_reg[DSTO_W-1]}}, dy0_reg};
            j_cnt_next = ny_reg;
        end
        if (cmd.pix_step)
        begin
            y1_next    = (y1_inc >= {1'b0, sh}) ? '0 : y1_inc[DIM_W-1:0];
            y2_next    = y2_reg + 1'b1;
            j_cnt_next = j_cnt_reg - 1'b1;
            if (sts.row_last)
            begin
                // column done: advance source column with wrap
                x1_next    = (x1_inc >= {1'b0, sw}) ? '0 : x1_inc[DIM_W-1:0];
                x2_next    = x2_reg + 1'b1;
                i_cnt_next = i_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        sy0_reg   <= sy0_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        dy0_reg   <= dy0_next;
        i_cnt_reg <= i_cnt_next;
        j_cnt_reg <= j_cnt_next;
        ny_reg    <= ny_next;
        sbase_reg <= sbase_next;
        dbase_reg <= dbase_next;
    end

    // ------------------------------------------------------------ write-back
    assign pend_next      = cmd.pix_step;
    assign pend_sok_next  = src_ok;
    assign pend_dok_next  = dst_ok;
    assign pend_di_next   = AW'(di);
    assign rd_inside_next = cmd.accept ? host_inside : rd_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sok_reg  <= pend_sok_next;
        pend_dok_reg  <= pend_dok_next;
        pend_di_reg   <= pend_di_next;
        rd_inside_reg <= rd_inside_next;
    end

    // source beyond the store reads as zero
    assign blit_pix    = pend_sok_reg ? src_rdata : '0;
    assign blit_we     = pend_reg && pend_dok_reg && (blit_pix != TRANSPARENT_PIXEL);
    assign src_we      = cmd.accept && (func == FN_WR_SRC) && host_inside;
    assign host_dst_we = cmd.accept && (func == FN_WR_DST) && host_inside;
    assign dst_we      = host_dst_we || blit_we;
    assign dst_waddr   = blit_we ? pend_di_reg : host_addr;
    assign dst_wdata   = blit_we ? blit_pix : pixel_in;

    tpb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TILE_PIXELS)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (host_addr),
        .wdata (pixel_in),
        .raddr (AW'(si)),
        .rdata (src_rdata)
    );

    tpb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TILE_PIXELS)
    ) u_dst_ram (
        .clk   (clk),
        .we    (dst_we),
        .waddr (dst_waddr),
        .wdata (dst_wdata),
        .raddr (host_addr),
        .rdata (dst_rdata)
    );

    // ------------------------------------------------------------ result
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_pixel_next  = out_pixel_reg;
        out_status_next = out_status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push_read)
        begin
            out_valid_next  = 1'b1;
            out_pixel_next  = rd_inside_reg ? dst_rdata : '0;
            out_status_next = STAT_OK;
        end
        else if (cmd.push_blit)
        begin
            out_valid_next  = 1'b1;
            out_pixel_next  = '0;
            out_status_next = cmd.accept ? blit_status : STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg  <= out_pixel_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_DATA_W-PIX_W-STAT_W){1'b0}}, out_status_reg, out_pixel_reg};

endmodule

`default_nettype wire

// File: hdl/tile_piece_blit_chk.sv
// ----------------------------------------------------------------------------
// tile_piece_blit_chk
// Port-level checks for tile_piece_blit_top, bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tile_piece_blit_top_assert.svh"

module tile_piece_blit_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [tpb_pkg::FUNC_W-1:0]       s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [tpb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import tpb_pkg::*;

    logic in_beat;
    logic rd_beat;
    logic wr_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign rd_beat = in_beat && (s_axis_tuser == FN_RD_DST);
    assign wr_beat = in_beat && ((s_axis_tuser == FN_WR_SRC) || (s_axis_tuser == FN_WR_DST));

    // hold a stalled result
    `TPB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // a write never raises a result
    `TPB_ASSERT_NEXT(a_wr_silent, wr_beat && !m_axis_tvalid, !m_axis_tvalid,
        "pixel write produced a result")

    // a read holds off the input while in flight, then answers with ok status
    `TPB_ASSERT_NEXT(a_rd_result, rd_beat,
        !s_axis_tready ##1 (m_axis_tvalid && m_axis_tdata[9:8] == STAT_OK),
        "read result missing or wrong status")

    // a failed blit carries a zero pixel and a valid status code
    `TPB_ASSERT_NOW(a_stat_pixel, m_axis_tvalid && m_axis_tdata[9:8] != STAT_OK,
        m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[9:8] != 2'd3,
        "blit status with nonzero pixel or bad code")

endmodule

bind tile_piece_blit_top tile_piece_blit_chk u_tpb_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
